// ===== rtl/core/swtm_pkg.sv =====
// swtm_pkg: shared types and constants for the sliding-window trimmed mean.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swtm_pkg;
    localparam int WINDOW_MAX_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_BITS  = 6;
    localparam int TRIM_BITS = 4;
    localparam int MEAN_BITS = 16;
    localparam logic [LEN_BITS-1:0]  LEN_RESET  = 6'd3;
    localparam logic [TRIM_BITS-1:0] TRIM_RESET = 4'd1;

    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_TRIM_COUNT    = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_SCAN,
        WS_REMOVE,
        WS_INSERT,
        WS_TRIM,
        WS_HAND
    } win_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/swtm_window.sv =====
// swtm_window: front part; keeps the ring and the sorted window, the running
// totals, and hands one division job per sample. Depends on swtm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtm_window #(
    parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic [swtm_pkg::LEN_BITS-1:0] len_cfg,
    input  wire logic [swtm_pkg::TRIM_BITS-1:0] trim_cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [SAMPLE_BITS-1:0]        in_sample,
    output logic                               job_valid,
    input  wire logic                          job_ready,
    output logic                               job_ok,
    output logic [SUM_BITS-1:0]                job_num,
    output logic [swtm_pkg::LEN_BITS-1:0]      job_den
);
    import swtm_pkg::*;
    localparam int IDX_BITS = $clog2(WINDOW_MAX);
    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int EL_BITS  = (CNT_BITS > LEN_BITS) ? CNT_BITS : LEN_BITS;

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sort_reg [WINDOW_MAX];

    win_state_t             state_reg, state_next;
    logic [CNT_BITS-1:0]    fill_reg, fill_next;
    logic [IDX_BITS-1:0]    head_reg, head_next;
    logic [SUM_BITS-1:0]    total_reg, total_next;
    logic [SUM_BITS-1:0]    trim_sum_reg, trim_sum_next;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [CNT_BITS-1:0]    pos_reg, pos_next;
    logic [TRIM_BITS-1:0]   ti_reg, ti_next;
    logic                   full_reg, full_next;
    logic [EL_BITS-1:0]     len_eff;
    logic [EL_BITS-1:0]     two_k;
    logic [IDX_BITS-1:0]    slot;
    logic [EL_BITS:0]       slot_sum;
    logic [CNT_BITS-1:0]    rm_pos;
    logic [CNT_BITS-1:0]    ins_pos;
    logic [CNT_BITS-1:0]    base_cnt;

    assign len_eff = (EL_BITS'(len_cfg) > EL_BITS'(WINDOW_MAX)) ? EL_BITS'(WINDOW_MAX)
                                                                 : EL_BITS'(len_cfg);
    assign two_k = EL_BITS'({trim_cfg, 1'b0});
    assign in_ready = (state_reg == WS_IDLE);
    assign slot_sum = (EL_BITS + 1)'(head_reg) + (EL_BITS + 1)'(fill_reg);
    assign slot = (slot_sum >= (EL_BITS + 1)'(len_eff))
                  ? IDX_BITS'(slot_sum - (EL_BITS + 1)'(len_eff)) : IDX_BITS'(slot_sum);

    // first matching entry for removal, insertion point after removal
    always_comb
    begin
        rm_pos = CNT_BITS'(0);
        for (int i = WINDOW_MAX - 1; i >= 0; i--)
        begin
            if (CNT_BITS'(i) < fill_reg && sort_reg[i] == old_reg)
            begin
                rm_pos = CNT_BITS'(i);
            end
        end
    end

    assign base_cnt = full_reg ? CNT_BITS'(fill_reg - 1'b1) : fill_reg;
    always_comb
    begin
        ins_pos = base_cnt;
        for (int i = WINDOW_MAX - 1; i >= 0; i--)
        begin
            if (CNT_BITS'(i) < base_cnt && sort_reg[i] > samp_reg)
            begin
                ins_pos = CNT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        head_next     = head_reg;
        total_next    = total_reg;
        trim_sum_next = trim_sum_reg;
        pos_next      = pos_reg;
        ti_next       = ti_reg;
        full_next     = full_reg;
        job_valid     = 1'b0;
        unique case (state_reg)
            WS_IDLE:
            begin
                if (in_valid && len_eff != '0)
                begin
                    full_next = (EL_BITS'(fill_reg) >= len_eff);
                    state_next = WS_SCAN;
                end
                else if (in_valid)
                begin
                    state_next = WS_HAND;
                    trim_sum_next = '0;
                end
            end
            WS_SCAN:
            begin
                if (full_reg)
                begin
                    pos_next = rm_pos;
                    total_next = total_reg - SUM_BITS'(old_reg) + SUM_BITS'(samp_reg);
                    state_next = WS_REMOVE;
                end
                else
                begin
                    total_next = total_reg + SUM_BITS'(samp_reg);
                    state_next = WS_INSERT;
                end
            end
            WS_REMOVE:
            begin
                state_next = WS_INSERT;
            end
            WS_INSERT:
            begin
                if (!full_reg)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                trim_sum_next = '0;
                ti_next = '0;
                state_next = WS_TRIM;
            end
            WS_TRIM:
            begin
                if (ti_reg == trim_cfg || EL_BITS'(fill_reg) <= two_k)
                begin
                    if (EL_BITS'(fill_reg) <= two_k)
                    begin
                        trim_sum_next = '0;
                    end
                    state_next = WS_HAND;
                end
                else
                begin
                    trim_sum_next = trim_sum_reg
                        + SUM_BITS'(sort_reg[IDX_BITS'(ti_reg)])
                        + SUM_BITS'(sort_reg[IDX_BITS'(fill_reg - 1'b1 - CNT_BITS'(ti_reg))]);
                    ti_next = ti_reg + 1'b1;
                end
            end
            WS_HAND:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = WS_IDLE;
                end
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ok  = (len_eff != '0) && (EL_BITS'(fill_reg) == len_eff) && (two_k < len_eff);
        job_num = total_reg - trim_sum_reg;
        job_den = LEN_BITS'(len_eff - two_k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= WS_IDLE;
            fill_reg     <= '0;
            head_reg     <= '0;
            total_reg    <= '0;
            trim_sum_reg <= '0;
            pos_reg      <= '0;
            ti_reg       <= '0;
            full_reg     <= 1'b0;
        end
        else if (clear)
        begin
            fill_reg     <= '0;
            head_reg     <= '0;
            total_reg    <= '0;
            trim_sum_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            total_reg    <= total_next;
            trim_sum_reg <= trim_sum_next;
            pos_reg      <= pos_next;
            ti_reg       <= ti_next;
            full_reg     <= full_next;
            if (state_reg == WS_SCAN && full_reg)
            begin
                head_reg <= (EL_BITS'(head_reg) + 1'b1 >= len_eff) ? '0 : head_reg + 1'b1;
            end
        end
    end

    // payload: sample capture, ring and sorted window
    always_ff @(posedge clk)
    begin
        if (state_reg == WS_IDLE && in_valid)
        begin
            samp_reg <= in_sample;
            old_reg  <= ring_mem[head_reg];
        end
        if (state_reg == WS_SCAN)
        begin
            ring_mem[full_reg ? head_reg : slot] <= samp_reg;
        end
        if (state_reg == WS_REMOVE)
        begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
            begin
                if (CNT_BITS'(i) >= pos_reg && CNT_BITS'(i + 1) < fill_reg)
                begin
                    sort_reg[i] <= sort_reg[i + 1];
                end
            end
        end
        if (state_reg == WS_INSERT)
        begin
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                if (CNT_BITS'(i) > ins_pos && CNT_BITS'(i) <= base_cnt)
                begin
                    sort_reg[i] <= sort_reg[i - 1];
                end
            end
            sort_reg[IDX_BITS'(ins_pos)] <= samp_reg;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EL_BITS'(fill_reg) <= EL_BITS'(WINDOW_MAX))
        else $error("fill count beyond window");
    a_hand_held: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready && !clear |=> job_valid)
        else $error("job dropped");
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !in_ready)
        else $error("accept while handing job");
endmodule
`default_nettype wire

// ===== rtl/core/swtm_divider.sv =====
// swtm_divider: back part; restoring divider one quotient bit per cycle and
// one-entry result register. Depends on swtm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtm_divider #(
    parameter int SUM_BITS = 21
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    output logic                               job_ready,
    input  wire logic                          job_ok,
    input  wire logic [SUM_BITS-1:0]           job_num,
    input  wire logic [swtm_pkg::LEN_BITS-1:0] job_den,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               mean_valid,
    output logic [swtm_pkg::MEAN_BITS-1:0]     trimmed_mean
);
    import swtm_pkg::*;
    localparam int CNT_W = $clog2(SUM_BITS + 1);

    div_state_t             state_reg, state_next;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [LEN_BITS:0]      rem_reg;
    logic [LEN_BITS-1:0]    den_reg;
    logic                   ok_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [LEN_BITS:0]      trial;

    assign trial = {rem_reg[LEN_BITS-1:0], quo_reg[SUM_BITS-1]};
    assign job_ready = (state_reg == DV_IDLE);
    assign empty = (state_reg != DV_DONE);
    assign mean_valid = ok_reg;
    assign trimmed_mean = ok_reg ? MEAN_BITS'(quo_reg) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (job_valid) state_next = DV_RUN;
            DV_RUN:  if (cnt_reg == CNT_W'(1)) state_next = DV_DONE;
            DV_DONE: if (pop) state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DV_IDLE && job_valid)
            begin
                cnt_reg <= CNT_W'(SUM_BITS);
            end
            else if (state_reg == DV_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && job_valid)
        begin
            quo_reg <= job_num;
            rem_reg <= '0;
            den_reg <= job_den;
            ok_reg  <= job_ok;
        end
        else if (state_reg == DV_RUN)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DV_RUN |-> cnt_reg != '0)
        else $error("divider count underflow");
    a_take_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> state_reg == DV_RUN)
        else $error("job not started");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(trimmed_mean))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

// ===== rtl/core/sliding_window_trimmed_mean.sv =====
// Top level: config registers, window front part and divider back part.
// Depends on swtm_pkg, swtm_window, swtm_divider.
//   channel   | signals                          | request
//   input     | push, full, sample               | one sample
//   result    | empty, pop, mean_valid, trimmed_mean | one mean
//   config    | cfg_we, cfg_index, cfg_data      | register write
// An item passes the window part through the scan, remove (only when full),
// insert, trim and hand-off states, then the serial divider, which holds its
// result until pop; the divider sets the rate.
// The window part takes the next sample while the divider works.
// Reset clears the window; a config write empties it as well.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_trimmed_mean #(
    parameter int WINDOW_MAX  = swtm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swtm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [SAMPLE_BITS-1:0]         sample,
    output logic                                empty,
    input  wire logic                           pop,
    output logic                                mean_valid,
    output logic [swtm_pkg::MEAN_BITS-1:0]      trimmed_mean,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [swtm_pkg::LEN_BITS-1:0]  cfg_data
);
    import swtm_pkg::*;
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX + 1);

    logic [LEN_BITS-1:0]  len_reg;
    logic [TRIM_BITS-1:0] trim_reg;
    logic                 in_ready;
    logic                 job_valid, job_ready, job_ok;
    logic [SUM_BITS-1:0]  job_num;
    logic [LEN_BITS-1:0]  job_den;

    assign full = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            trim_reg <= TRIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WINDOW_LENGTH: len_reg  <= cfg_data;
                REG_TRIM_COUNT:    trim_reg <= cfg_data[TRIM_BITS-1:0];
                default:           len_reg  <= len_reg;
            endcase
        end
    end

    swtm_window #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_we),
        .len_cfg   (len_reg),
        .trim_cfg  (trim_reg),
        .in_valid  (push),
        .in_ready  (in_ready),
        .in_sample (sample),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_ok    (job_ok),
        .job_num   (job_num),
        .job_den   (job_den)
    );

    swtm_divider #(
        .SUM_BITS (SUM_BITS)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job_ok       (job_ok),
        .job_num      (job_num),
        .job_den      (job_den),
        .empty        (empty),
        .pop          (pop),
        .mean_valid   (mean_valid),
        .trimmed_mean (trimmed_mean)
    );
endmodule
`default_nettype wire
